[design/accumulator_cpu_instruction_step_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ACCUMULATOR_CPU_INSTRUCTION_STEP_MACROS_SVH
`define ACCUMULATOR_CPU_INSTRUCTION_STEP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ACS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define ACS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[design/acs_pkg.sv]
// Package: widths, opcodes, status codes and shared types of the accumulator processor.
`timescale 1ns / 1ps
package acs_pkg;
   localparam int MemBytesDefault   = 2048;
   localparam int IoBytesDefault    = 32;
   localparam int QueueDepthDefault = 2;
   localparam int AddrW = 11;

   typedef enum logic [1:0] {
      MODE_LOAD = 2'd0, MODE_SETIO = 2'd1, MODE_EXEC = 2'd2, MODE_RESTART = 2'd3
   } mode_type;

   localparam logic [1:0] ST_RUN = 2'd0;
   localparam logic [1:0] ST_EOP = 2'd1;
   localparam logic [1:0] ST_ERR = 2'd2;

   localparam logic [4:0] OP_WM   = 5'd1;
   localparam logic [4:0] OP_RM   = 5'd2;
   localparam logic [4:0] OP_BR   = 5'd3;
   localparam logic [4:0] OP_RIO  = 5'd4;
   localparam logic [4:0] OP_WIO  = 5'd5;
   localparam logic [4:0] OP_WB   = 5'd6;
   localparam logic [4:0] OP_WIB  = 5'd7;
   localparam logic [4:0] OP_WACC = 5'd9;
   localparam logic [4:0] OP_RACC = 5'd11;
   localparam logic [4:0] OP_SWAP = 5'd14;
   localparam logic [4:0] OP_BRLT = 5'd17;
   localparam logic [4:0] OP_BRGT = 5'd18;
   localparam logic [4:0] OP_BRNE = 5'd19;
   localparam logic [4:0] OP_BRE  = 5'd20;
   localparam logic [4:0] OP_SHR  = 5'd21;
   localparam logic [4:0] OP_SHL  = 5'd22;
   localparam logic [4:0] OP_XOR  = 5'd23;
   localparam logic [4:0] OP_NOT  = 5'd24;
   localparam logic [4:0] OP_OR   = 5'd25;
   localparam logic [4:0] OP_AND  = 5'd26;
   localparam logic [4:0] OP_MUL  = 5'd27;
   localparam logic [4:0] OP_SUB  = 5'd29;
   localparam logic [4:0] OP_ADD  = 5'd30;
   localparam logic [4:0] OP_EOP  = 5'd31;

   // Classified item handed from front to back.
   typedef struct packed {
      mode_type         mode;
      logic [AddrW-1:0] addr;
      logic [7:0]       data;
      logic             io_ok;  // addr in input buffer range
   } item_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [AddrW-1:0] prog_counter;
      logic [4:0]       last_opcode;
      logic [7:0]       accum;
      logic [3:0]       flag_bits;
      logic [7:0]       mem_buffer;
      logic [7:0]       io_buffer;
      logic             latch_write;
      logic [3:0]       latch_index;
      logic [7:0]       latch_value;
   } result_type;
endpackage

[design/acs_front.sv]
// Front end: accepts request transfers, classifies them and queues them for execution.
`timescale 1ns / 1ps
module acs_front import acs_pkg::*; #(
   parameter int QueueDepth = QueueDepthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_mode,
   input  logic [AddrW-1:0] req_addr,
   input  logic [7:0]       req_data,
   output logic             item_valid,
   input  logic             item_take,
   output item_type         item
);
   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

   item_type          q_ff [QueueDepth];
   logic [PtrW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]     cnt_ff, cnt_in;
   logic              push, pop;
   item_type          new_item;

   assign req_stall  = (cnt_ff == (PtrW+1)'(QueueDepth));
   assign push       = req_valid && !req_stall;
   assign item_valid = (cnt_ff != '0);
   assign pop        = item_valid && item_take;
   assign item       = q_ff[rd_ff];

   always_comb begin
      new_item.mode  = mode_type'(req_mode);
      new_item.addr  = req_addr;
      new_item.data  = req_data;
      new_item.io_ok = (req_addr >= AddrW'(16)) && (req_addr <= AddrW'(31));
      wr_in  = push ? ((wr_ff == PtrW'(QueueDepth-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? ((rd_ff == PtrW'(QueueDepth-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= new_item;
   end
endmodule

[design/acs_back.sv]
// Back end: sequencer that executes queued items against memory and registers.
`timescale 1ns / 1ps
module acs_back import acs_pkg::*; #(
   parameter int MemBytes = MemBytesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   output logic       item_take,
   input  item_type   item,
   output logic       res_valid,
   input  logic       res_stall,
   output result_type res
);
   localparam int MemAw = $clog2(MemBytes);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_HI = 6'b000010, S_LO = 6'b000100,
      S_EXEC = 6'b001000, S_DATA = 6'b010000, S_OUT = 6'b100000
   } state_type;

   state_type        st_ff, st_in;
   logic [7:0]       mem [MemBytes];
   logic [7:0]       io_ff [IoBytesDefault];
   logic [7:0]       rd_data_ff;
   logic [MemAw-1:0] m_addr;
   logic             m_we;
   logic [7:0]       m_wdata;
   logic [AddrW-1:0] pc_ff;
   logic [7:0]       acc_ff, mbr_ff, iobr_ff, hi_ff;
   logic [3:0]       flags_ff;
   logic [1:0]       run_ff;
   item_type         cur_ff;
   result_type       res_ff;
   logic             out_ff, out_in;   // result register occupied
   logic             commit;
   logic [4:0]       opc;
   logic [AddrW-1:0] opd, opd_ff;
   logic [15:0]      prod_ff;
   // per-item outcome, copied into the result register on commit
   logic [4:0]       lop_ff;
   logic             lw_ff;
   logic [3:0]       li_ff;
   logic [7:0]       lv_ff;

   assign opc = hi_ff[7:3];
   assign opd = {hi_ff[2:0], rd_data_ff};
   assign res_valid = out_ff;
   assign res = res_ff;
   assign item_take = (st_ff == S_IDLE) && item_valid;
   assign commit = (st_ff == S_OUT) && (!out_ff || !res_stall);

   always_comb begin
      m_addr  = cur_ff.addr[MemAw-1:0];
      m_we    = 1'b0;
      m_wdata = cur_ff.data;
      case (st_ff)
         S_HI:    m_addr = pc_ff[MemAw-1:0];
         S_LO:    m_addr = pc_ff[MemAw-1:0] + 1'b1;
         S_EXEC: begin
            m_addr  = opd[MemAw-1:0];
            m_we    = (opc == OP_WM);
            m_wdata = mbr_ff;
         end
         // keep the data read steady while the result waits
         S_OUT:   m_addr = opd_ff[MemAw-1:0];
         default: begin
            m_addr = cur_ff.addr[MemAw-1:0];
            m_we   = (st_ff == S_DATA) && (cur_ff.mode == MODE_LOAD);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (m_we) mem[m_addr] <= m_wdata;
      rd_data_ff <= mem[m_addr];
   end

   function automatic logic [3:0] arith(input logic [15:0] r);
      arith = {r[15:8] != 8'd0, r[7], r[15:8] != 8'd0, r[7:0] == 8'd0};
   endfunction

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE: if (item_valid) st_in = S_DATA;
         S_DATA: begin
            if (cur_ff.mode == MODE_EXEC && run_ff == ST_RUN) st_in = S_HI;
            else st_in = S_OUT;
         end
         S_HI:   st_in = S_LO;
         S_LO:   st_in = S_EXEC;
         S_EXEC: st_in = S_OUT;
         S_OUT:  if (commit) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_comb begin
      out_in = out_ff;
      if (out_ff && !res_stall) out_in = 1'b0;
      if (commit) out_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      logic [8:0]       sum;
      logic [3:0]       f;
      logic             take;
      logic [AddrW-1:0] pc_in;
      logic             is_rm, is_mul;
      sum    = '0;
      f      = '0;
      take   = 1'b0;
      pc_in  = pc_ff;
      is_rm  = (cur_ff.mode == MODE_EXEC) && (lop_ff == OP_RM);
      is_mul = (cur_ff.mode == MODE_EXEC) && (lop_ff == OP_MUL);
      if (reset) begin
         st_ff <= S_IDLE;
         out_ff <= 1'b0;
         pc_ff <= '0; acc_ff <= '0; mbr_ff <= '0; iobr_ff <= '0;
         flags_ff <= '0; run_ff <= ST_RUN;
         for (int i = 0; i < IoBytesDefault; i++) io_ff[i] <= '0;
      end else begin
         st_ff <= st_in;
         out_ff <= out_in;
         case (st_ff)
            S_IDLE: if (item_valid) begin
               cur_ff <= item;
               lop_ff <= '0;
               lw_ff  <= 1'b0;
               li_ff  <= '0;
               lv_ff  <= '0;
            end
            S_DATA: begin
               if (cur_ff.mode == MODE_SETIO && cur_ff.io_ok)
                  io_ff[cur_ff.addr[4:0]] <= cur_ff.data;
               if (cur_ff.mode == MODE_RESTART) begin
                  pc_ff <= '0; acc_ff <= '0; mbr_ff <= '0; iobr_ff <= '0;
                  flags_ff <= '0; run_ff <= ST_RUN;
               end
            end
            S_HI: ;
            S_LO: hi_ff <= rd_data_ff;
            S_EXEC: begin
               // rd_data_ff holds the low instruction byte here
               pc_in = pc_ff + AddrW'(2);
               lop_ff <= opc;
               opd_ff <= opd;
               sum = {1'b0, acc_ff} + {1'b0, (~mbr_ff) + 8'd1};
               if (mbr_ff == 8'd0) sum[8] = 1'b0;
               case (opc)
                  OP_WM:   ;
                  OP_RM:   ;
                  OP_BR:   pc_in = opd;
                  OP_RIO:  iobr_ff <= (opd >= AddrW'(16) && opd <= AddrW'(31))
                                      ? io_ff[opd[4:0]] : rd_data_ff;
                  OP_WIO:  if (opd <= AddrW'(15)) begin
                     io_ff[opd[4:0]] <= iobr_ff;
                     lw_ff <= 1'b1;
                     li_ff <= opd[3:0];
                     lv_ff <= iobr_ff;
                  end
                  OP_WB:   mbr_ff <= rd_data_ff;
                  OP_WIB:  iobr_ff <= rd_data_ff;
                  OP_WACC: acc_ff <= mbr_ff;
                  OP_RACC: mbr_ff <= acc_ff;
                  OP_SWAP: begin mbr_ff <= iobr_ff; iobr_ff <= mbr_ff; end
                  OP_BRLT, OP_BRGT, OP_BRNE, OP_BRE: begin
                     f = arith({7'd0, sum});
                     flags_ff <= f;
                     take = (opc == OP_BRLT) ? f[2] :
                            (opc == OP_BRGT) ? (!f[2] && !f[0]) :
                            (opc == OP_BRNE) ? !f[0] : f[0];
                     if (take) pc_in = opd;
                  end
                  OP_SHR: begin flags_ff[1] <= acc_ff[0]; acc_ff <= acc_ff >> 1; end
                  OP_SHL: begin flags_ff[1] <= acc_ff[7]; acc_ff <= acc_ff << 1; end
                  OP_XOR: begin acc_ff <= acc_ff ^ mbr_ff;
                     flags_ff[0] <= (acc_ff ^ mbr_ff) == 8'd0; end
                  OP_NOT: begin acc_ff <= ~acc_ff; flags_ff[0] <= (~acc_ff) == 8'd0; end
                  OP_OR:  begin acc_ff <= acc_ff | mbr_ff;
                     flags_ff[0] <= (acc_ff | mbr_ff) == 8'd0; end
                  OP_AND: begin acc_ff <= acc_ff & mbr_ff;
                     flags_ff[0] <= (acc_ff & mbr_ff) == 8'd0; end
                  OP_MUL: begin prod_ff <= acc_ff * mbr_ff; end
                  OP_SUB: begin acc_ff <= sum[7:0]; flags_ff <= arith({7'd0, sum}); end
                  OP_ADD: begin
                     acc_ff <= acc_ff + mbr_ff;
                     flags_ff <= arith({7'd0, {1'b0, acc_ff} + {1'b0, mbr_ff}});
                  end
                  OP_EOP: run_ff <= ST_EOP;
                  default: run_ff <= ST_ERR;
               endcase
               pc_ff <= pc_in;
            end
            S_OUT: if (commit) begin
               // finish the RM and MUL ops using registered memory read / product
               if (is_rm) mbr_ff <= rd_data_ff;
               if (is_mul) begin
                  acc_ff <= prod_ff[7:0];
                  flags_ff <= arith(prod_ff);
               end
               res_ff.status       <= run_ff;
               res_ff.prog_counter <= pc_ff;
               res_ff.last_opcode  <= lop_ff;
               res_ff.accum        <= is_mul ? prod_ff[7:0] : acc_ff;
               res_ff.flag_bits    <= is_mul ? arith(prod_ff) : flags_ff;
               res_ff.mem_buffer   <= is_rm ? rd_data_ff : mbr_ff;
               res_ff.io_buffer    <= iobr_ff;
               res_ff.latch_write  <= lw_ff;
               res_ff.latch_index  <= li_ff;
               res_ff.latch_value  <= lv_ff;
            end
            default: ;
         endcase
      end
   end
endmodule

[design/accumulator_cpu_instruction_step.sv]
// Top level of the stepped 8-bit accumulator processor.
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  mode, addr, data
//  rsp_      out        rsp_valid/rsp_stall  status .. latch_value
// Execute items, while the program runs, pass through queue pop, setup, two byte
// fetches from the single-port memory, execute and result load; other items go from setup to result load.
// Reset is synchronous; memory contents are not cleared, I/O bytes are.
// A two-entry queue keeps taking requests, until it is full, while the back end
// works or the result register waits on rsp_stall.
`timescale 1ns / 1ps
module accumulator_cpu_instruction_step import acs_pkg::*; #(
   parameter int MEM_BYTES = MemBytesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_mode,
   input  logic [AddrW-1:0] req_addr,
   input  logic [7:0]       req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [AddrW-1:0] rsp_prog_counter,
   output logic [4:0]       rsp_last_opcode,
   output logic [7:0]       rsp_accum,
   output logic [3:0]       rsp_flag_bits,
   output logic [7:0]       rsp_mem_buffer,
   output logic [7:0]       rsp_io_buffer,
   output logic             rsp_latch_write,
   output logic [3:0]       rsp_latch_index,
   output logic [7:0]       rsp_latch_value
);
   logic       item_valid, item_take;
   item_type   item;
   result_type res;

   acs_front #(.QueueDepth(QueueDepthDefault)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_mode, .req_addr, .req_data,
      .item_valid, .item_take, .item
   );

   acs_back #(.MemBytes(MEM_BYTES)) u_back (
      .clock, .reset, .item_valid, .item_take, .item,
      .res_valid(rsp_valid), .res_stall(rsp_stall), .res
   );

   assign rsp_status       = res.status;
   assign rsp_prog_counter = res.prog_counter;
   assign rsp_last_opcode  = res.last_opcode;
   assign rsp_accum        = res.accum;
   assign rsp_flag_bits    = res.flag_bits;
   assign rsp_mem_buffer   = res.mem_buffer;
   assign rsp_io_buffer    = res.io_buffer;
   assign rsp_latch_write  = res.latch_write;
   assign rsp_latch_index  = res.latch_index;
   assign rsp_latch_value  = res.latch_value;
endmodule

[design/acs_checker.sv]
// Port-level checker for the accumulator processor, bound to the top level.
`timescale 1ns / 1ps
`include "accumulator_cpu_instruction_step_macros.svh"
module acs_checker import acs_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [1:0]       rsp_status,
   input logic [4:0]       rsp_last_opcode,
   input logic             rsp_latch_write,
   input logic [3:0]       rsp_latch_index,
   input logic [7:0]       rsp_latch_value
);
   `ACS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp dropped")
   `ACS_ASSERT_IMP(a_status, clock, reset, rsp_valid, rsp_status != 2'd3, "bad status")
   `ACS_ASSERT_IMP(a_latch_op, clock, reset, rsp_valid && rsp_latch_write, rsp_last_opcode == OP_WIO, "latch without WIO")
   `ACS_ASSERT_IMP(a_latch_zero, clock, reset, rsp_valid && !rsp_latch_write, rsp_latch_index == 4'd0 && rsp_latch_value == 8'd0, "latch fields nonzero")
endmodule

bind accumulator_cpu_instruction_step acs_checker u_acs_checker (.*);

[tb/sv/accumulator_cpu_instruction_step_checker.sv]
// Checker: predicts processor results from accepted requests and compares them.
`timescale 1ns / 1ps
module accumulator_cpu_instruction_step_checker import acs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic [1:0]       req_mode,
   input  logic [AddrW-1:0] req_addr,
   input  logic [7:0]       req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic [1:0]       rsp_status,
   input  logic [AddrW-1:0] rsp_prog_counter,
   input  logic [4:0]       rsp_last_opcode,
   input  logic [7:0]       rsp_accum,
   input  logic [3:0]       rsp_flag_bits,
   input  logic [7:0]       rsp_mem_buffer,
   input  logic [7:0]       rsp_io_buffer,
   input  logic             rsp_latch_write,
   input  logic [3:0]       rsp_latch_index,
   input  logic [7:0]       rsp_latch_value,
   output int               fail_count,
   output int               pending
);
   localparam logic [3:0] F_Z = 4'b0001;
   localparam logic [3:0] F_C = 4'b0010;
   localparam logic [3:0] F_S = 4'b0100;

   logic [7:0]       main_mem [MemBytesDefault];
   logic [7:0]       io_mem [IoBytesDefault];
   logic [AddrW-1:0] pc;
   logic [7:0]       acc, mbr, iobr;
   logic [3:0]       flags;
   logic [1:0]       run_st;
   result_type       expected_q [$];

   function automatic void clear_regs();
      pc = '0; acc = '0; mbr = '0; iobr = '0; flags = '0; run_st = ST_RUN;
   endfunction

   function automatic logic [3:0] arith_flags(logic [15:0] r);
      logic [3:0] f;
      f = '0;
      if (r[7:0] == 8'h00) f |= F_Z;
      if (r > 16'h00FF) f |= 4'b1010;
      if (r[7]) f |= F_S;
      return f;
   endfunction

   function automatic result_type cpu_step(logic [1:0] m, logic [AddrW-1:0] a,
                                           logic [7:0] d);
      result_type       res;
      logic [7:0]       hi, lo;
      logic [4:0]       opc;
      logic [AddrW-1:0] opd;
      logic [15:0]      r;
      logic [7:0]       t;
      logic             take;
      res = '0;
      opc = '0;
      if (m == MODE_LOAD) begin
         main_mem[a] = d;
      end else if (m == MODE_SETIO) begin
         if (a >= 16 && a <= 31) io_mem[a[4:0]] = d;
      end else if (m == MODE_RESTART) begin
         clear_regs();
      end else if (run_st == ST_RUN) begin
         hi = main_mem[pc];
         lo = main_mem[pc + 11'd1];
         opc = hi[7:3];
         opd = {hi[2:0], lo};
         pc = pc + 11'd2;
         case (opc)
            OP_WM: main_mem[opd] = mbr;
            OP_RM: mbr = main_mem[opd];
            OP_BR: pc = opd;
            OP_RIO: iobr = (opd >= 16 && opd <= 31) ? io_mem[opd[4:0]] : lo;
            OP_WIO: begin
               if (opd <= 15) begin
                  io_mem[opd[4:0]] = iobr;
                  res.latch_write = 1'b1;
                  res.latch_index = opd[3:0];
                  res.latch_value = iobr;
               end
            end
            OP_WB: mbr = opd[7:0];
            OP_WIB: iobr = opd[7:0];
            OP_WACC: acc = mbr;
            OP_RACC: mbr = acc;
            OP_SWAP: begin
               t = mbr; mbr = iobr; iobr = t;
            end
            OP_BRLT, OP_BRGT, OP_BRNE, OP_BRE: begin
               r = {8'h00, acc} + {8'h00, 8'(-mbr)};
               flags = arith_flags(r);
               case (opc)
                  OP_BRLT: take = flags[2];
                  OP_BRGT: take = !flags[2] && !flags[0];
                  OP_BRNE: take = !flags[0];
                  default: take = flags[0];
               endcase
               if (take) pc = opd;
            end
            OP_SHR: begin
               flags[1] = acc[0]; acc = acc >> 1;
            end
            OP_SHL: begin
               flags[1] = acc[7]; acc = acc << 1;
            end
            OP_XOR, OP_NOT, OP_OR, OP_AND: begin
               case (opc)
                  OP_XOR: acc = acc ^ mbr;
                  OP_NOT: acc = ~acc;
                  OP_OR:  acc = acc | mbr;
                  default: acc = acc & mbr;
               endcase
               flags[0] = (acc == 8'h00);
            end
            OP_MUL, OP_SUB, OP_ADD: begin
               if (opc == OP_MUL) r = acc * mbr;
               else if (opc == OP_SUB) r = {8'h00, acc} + {8'h00, 8'(-mbr)};
               else r = {8'h00, acc} + {8'h00, mbr};
               flags = arith_flags(r);
               acc = r[7:0];
            end
            OP_EOP: run_st = ST_EOP;
            default: run_st = ST_ERR;
         endcase
      end
      res.status = run_st;
      res.prog_counter = pc;
      res.last_opcode = opc;
      res.accum = acc;
      res.flag_bits = flags;
      res.mem_buffer = mbr;
      res.io_buffer = iobr;
      return res;
   endfunction

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      foreach (main_mem[i]) main_mem[i] = '0;
   end

   assign pending = expected_q.size();

   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         foreach (io_mem[i]) io_mem[i] = '0;
         clear_regs();
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result transfer with nothing expected");
               fail_count++;
            end else begin
               e = expected_q.pop_front();
               check_field("status", e.status, rsp_status);
               check_field("prog_counter", e.prog_counter, rsp_prog_counter);
               check_field("last_opcode", e.last_opcode, rsp_last_opcode);
               check_field("accum", e.accum, rsp_accum);
               check_field("flag_bits", e.flag_bits, rsp_flag_bits);
               check_field("mem_buffer", e.mem_buffer, rsp_mem_buffer);
               check_field("io_buffer", e.io_buffer, rsp_io_buffer);
               check_field("latch_write", e.latch_write, rsp_latch_write);
               check_field("latch_index", e.latch_index, rsp_latch_index);
               check_field("latch_value", e.latch_value, rsp_latch_value);
            end
         end
         if (req_valid && !req_stall)
            expected_q.push_back(cpu_step(req_mode, req_addr, req_data));
      end
   end
endmodule

[tb/sv/accumulator_cpu_instruction_step_tb.sv]
// Testbench top: clock, reset, stimulus, idling and verdict for the processor.
`timescale 1ns / 1ps
module accumulator_cpu_instruction_step_tb;
   import acs_pkg::*;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [1:0]       req_mode = MODE_LOAD;
   logic [AddrW-1:0] req_addr = '0;
   logic [7:0]       req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [1:0]       rsp_status;
   logic [AddrW-1:0] rsp_prog_counter;
   logic [4:0]       rsp_last_opcode;
   logic [7:0]       rsp_accum;
   logic [3:0]       rsp_flag_bits;
   logic [7:0]       rsp_mem_buffer;
   logic [7:0]       rsp_io_buffer;
   logic             rsp_latch_write;
   logic [3:0]       rsp_latch_index;
   logic [7:0]       rsp_latch_value;
   int               fail_count, pending;

   int send_idle_pct = 19;
   int recv_idle_pct = 78;
   int phase = 0;
   int n_items = 0, n_exec = 0, n_programs = 0;

   // data bytes for RM/WM live here, away from program code
   localparam logic [AddrW-1:0] DATA_BASE = 11'd256;
   localparam int               DATA_SPAN = 256;

   localparam logic [4:0] VALID_OPS [23] = '{OP_WM, OP_RM, OP_BR, OP_RIO, OP_WIO,
      OP_WB, OP_WIB, OP_WACC, OP_RACC, OP_SWAP, OP_BRLT, OP_BRGT, OP_BRNE, OP_BRE,
      OP_SHR, OP_SHL, OP_XOR, OP_NOT, OP_OR, OP_AND, OP_MUL, OP_SUB, OP_ADD};
   localparam logic [4:0] BAD_OPS [8] = '{5'd0, 5'd8, 5'd10, 5'd12, 5'd13, 5'd15,
      5'd16, 5'd28};

   always #10 clock = ~clock;

   accumulator_cpu_instruction_step dut (.*);

   accumulator_cpu_instruction_step_checker chk (.*);

   // receiver: random stall, plus one long hold-off when the no-idle phase begins
   initial begin
      int hold;
      bit held;
      hold = 0;
      held = 0;
      forever begin
         @(posedge clock);
         if (phase == 2 && !held) begin
            held = 1;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic send(logic [1:0] m, logic [AddrW-1:0] a, logic [7:0] d);
      req_valid <= 1'b1;
      req_mode <= m;
      req_addr <= a;
      req_data <= d;
      do @(posedge clock); while (req_stall);
      n_items++;
      if (m == MODE_EXEC) n_exec++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // random mode; memory loads stay in the data area so code is untouched
   task automatic send_stray();
      logic [1:0]       m;
      logic [AddrW-1:0] a;
      m = 2'($urandom_range(3));
      a = 11'($urandom);
      if (m == MODE_LOAD) a = DATA_BASE + 11'($urandom_range(DATA_SPAN - 1));
      send(m, a, 8'($urandom));
   endtask

   task automatic put_word(logic [AddrW-1:0] a, logic [4:0] op, logic [AddrW-1:0] opd);
      send(MODE_LOAD, a, {op, opd[10:8]});
      send(MODE_LOAD, a + 11'd1, opd[7:0]);
   endtask

   // random program at address zero, then restart and step through it
   task automatic run_program();
      int               len;
      logic [4:0]       op;
      logic [AddrW-1:0] opd;
      len = $urandom_range(3, 16);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 3) op = BAD_OPS[$urandom_range(7)];
         else if ($urandom_range(99) < 3) op = OP_EOP;
         else op = VALID_OPS[$urandom_range(22)];
         opd = 11'($urandom);
         // fetches stay inside the program, data accesses inside the data area
         if (op inside {OP_BR, OP_BRLT, OP_BRGT, OP_BRNE, OP_BRE})
            opd = 11'(2 * $urandom_range(len - 1));
         else if (op inside {OP_RM, OP_WM})
            opd = DATA_BASE + 11'($urandom_range(DATA_SPAN - 1));
         else if (op inside {OP_RIO, OP_WIO} && $urandom_range(3) != 0)
            opd = 11'($urandom_range(31));
         put_word(11'(2 * i), op, opd);
      end
      put_word(11'(2 * len), OP_EOP, 11'($urandom));
      repeat ($urandom_range(0, 3))
         send(MODE_SETIO, 11'($urandom_range(16, 31)), 8'($urandom));
      send(MODE_RESTART, 11'($urandom), 8'($urandom));
      repeat ($urandom_range(4, 30)) begin
         if ($urandom_range(99) < 4) send_stray();
         else send(MODE_EXEC, 11'($urandom), 8'($urandom));
      end
      n_programs++;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // the data area gets defined values first
      for (int i = 0; i < DATA_SPAN; i++)
         send(MODE_LOAD, DATA_BASE + 11'(i), 8'($urandom));
      // directed: ALU extremes, I/O corner cases, wrap, halt and restart
      send(MODE_SETIO, 11'd16, 8'hA5);
      send(MODE_SETIO, 11'd31, 8'hFF);
      send(MODE_SETIO, 11'd5, 8'h11);
      send(MODE_SETIO, 11'd2047, 8'h22);
      put_word(11'd0, OP_WB, 11'h0FF);   put_word(11'd2, OP_WACC, 11'd0);
      put_word(11'd4, OP_ADD, 11'd0);    put_word(11'd6, OP_SUB, 11'd0);
      put_word(11'd8, OP_MUL, 11'd0);    put_word(11'd10, OP_RIO, 11'd16);
      put_word(11'd12, OP_RIO, 11'h7E3); put_word(11'd14, OP_WIO, 11'd15);
      put_word(11'd16, OP_WIO, 11'd16);  put_word(11'd18, OP_BRE, 11'd22);
      put_word(11'd20, OP_BR, 11'd2046); put_word(11'd2046, BAD_OPS[0], 11'd0);
      put_word(11'd22, OP_BR, 11'd2046);
      send(MODE_RESTART, '1, '1);
      repeat (10) send(MODE_EXEC, '1, '1);
      send(MODE_LOAD, 11'd2046, {OP_EOP, 3'b000});
      send(MODE_RESTART, '0, '0);
      repeat (12) send(MODE_EXEC, '0, '0);
      send(MODE_EXEC, '0, '0);
      send(MODE_LOAD, 11'd2046, {OP_BR, 3'b000});
      send(MODE_RESTART, '0, '0);
      repeat (13) send(MODE_EXEC, '0, '0);
      while (n_items < 1650) begin
         if (phase == 0 && n_items > 550) begin
            phase = 1; send_idle_pct = 78; recv_idle_pct = 19;
         end else if (phase == 1 && n_items > 1100) begin
            phase = 2; send_idle_pct = 0; recv_idle_pct = 0;
         end
         if ($urandom_range(9) == 0) send_stray();
         else run_program();
      end
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d transfers, %0d executes over %0d random programs",
               n_items, n_exec, n_programs);
      $display("three idling phases, one long result hold-off, %0d mismatches",
               fail_count);
      if (fail_count == 0) $display("accumulator_cpu_instruction_step_tb passed");
      else $display("accumulator_cpu_instruction_step_tb failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("accumulator_cpu_instruction_step_tb failed");
      $finish;
   end
endmodule

[accumulator_cpu_instruction_step.f]
+incdir+design
design/acs_pkg.sv
design/acs_front.sv
design/acs_back.sv
design/accumulator_cpu_instruction_step.sv
design/acs_checker.sv
tb/sv/accumulator_cpu_instruction_step_checker.sv
tb/sv/accumulator_cpu_instruction_step_tb.sv
